// File: src/epr_pkg.sv
`timescale 1ns / 1ps
package epr_pkg;

    // Q4.30 sine/cosine and coefficient width, CORDIC angle width
    localparam int EPR_CW = 34;
    localparam int EPR_ZW = 33;
    localparam int EPR_FRAC = 30;
    localparam int EPR_TAB_LEN = 24;

    localparam logic signed [EPR_CW-1:0] EPR_GAIN = 34'sd652032874;
    localparam logic signed [EPR_CW-1:0] EPR_ZERO = '0;

    // atan(2^-i), 2^32 units per turn
    function automatic logic signed [EPR_ZW-1:0] atan_val(input int idx);
        logic signed [EPR_ZW-1:0] v;
        begin
            case (idx)
                0:  v = 33'sd536870912;
                1:  v = 33'sd316933406;
                2:  v = 33'sd167458907;
                3:  v = 33'sd85004756;
                4:  v = 33'sd42667331;
                5:  v = 33'sd21354465;
                6:  v = 33'sd10679838;
                7:  v = 33'sd5340245;
                8:  v = 33'sd2670163;
                9:  v = 33'sd1335087;
                10: v = 33'sd667544;
                11: v = 33'sd333772;
                12: v = 33'sd166886;
                13: v = 33'sd83443;
                14: v = 33'sd41722;
                15: v = 33'sd20861;
                16: v = 33'sd10430;
                17: v = 33'sd5215;
                18: v = 33'sd2608;
                19: v = 33'sd1304;
                20: v = 33'sd652;
                21: v = 33'sd326;
                22: v = 33'sd163;
                23: v = 33'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Q4.30 product, rounded half up
    function automatic logic signed [EPR_CW-1:0] qmul(
        input logic signed [EPR_CW-1:0] a,
        input logic signed [EPR_CW-1:0] b
    );
        logic signed [2*EPR_CW-1:0] p;
        logic signed [2*EPR_CW-1:0] s;
        begin
            p = a * b;
            s = (p + (2*EPR_CW)'(64'sd536870912)) >>> EPR_FRAC;
            return s[EPR_CW-1:0];
        end
    endfunction

endpackage

// File: src/epr_if.sv
`timescale 1ns / 1ps
interface epr_in_if #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [ANGLE_BITS-1:0]        yaw_angle;
    logic [ANGLE_BITS-1:0]        pitch_angle;
    logic [ANGLE_BITS-1:0]        roll_angle;

    modport source (output valid, point_x, point_y, point_z, yaw_angle, pitch_angle,
                    roll_angle, input ready);
    modport sink (input valid, point_x, point_y, point_z, yaw_angle, pitch_angle,
                  roll_angle, output ready);
endinterface

interface epr_out_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic signed [COORD_BITS-1:0] rotated_z;
    logic                         saturated_flag;

    modport source (output valid, rotated_x, rotated_y, rotated_z, saturated_flag,
                    input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, saturated_flag,
                  output ready);
endinterface

// File: src/epr_cordic_stage.sv
`timescale 1ns / 1ps
// One CORDIC micro-rotation for the three angle lanes, registered.
module epr_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [epr_pkg::EPR_CW-1:0] i_x [3],
    input  logic signed [epr_pkg::EPR_CW-1:0] i_y [3],
    input  logic signed [epr_pkg::EPR_ZW-1:0] i_z [3],
    output logic signed [epr_pkg::EPR_CW-1:0] o_x [3],
    output logic signed [epr_pkg::EPR_CW-1:0] o_y [3],
    output logic signed [epr_pkg::EPR_ZW-1:0] o_z [3]
);
    logic signed [epr_pkg::EPR_CW-1:0] r_x [3];
    logic signed [epr_pkg::EPR_CW-1:0] r_y [3];
    logic signed [epr_pkg::EPR_ZW-1:0] r_z [3];
    logic signed [epr_pkg::EPR_CW-1:0] n_x [3];
    logic signed [epr_pkg::EPR_CW-1:0] n_y [3];
    logic signed [epr_pkg::EPR_ZW-1:0] n_z [3];
    logic signed [epr_pkg::EPR_ZW-1:0] w_atan;

    assign w_atan = epr_pkg::atan_val(STEP);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!i_z[l][epr_pkg::EPR_ZW-1]) begin
                n_x[l] = i_x[l] - (i_y[l] >>> STEP);
                n_y[l] = i_y[l] + (i_x[l] >>> STEP);
                n_z[l] = i_z[l] - w_atan;
            end else begin
                n_x[l] = i_x[l] + (i_y[l] >>> STEP);
                n_y[l] = i_y[l] - (i_x[l] >>> STEP);
                n_z[l] = i_z[l] + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// File: src/epr_coef.sv
`timescale 1ns / 1ps
// Rotation matrix: pair products, then triple products and sums.
// Lane 0 yaw, 1 pitch, 2 roll.
module epr_coef (
    input  logic                             i_clk,
    input  logic                             i_en_a,
    input  logic                             i_en_b,
    input  logic signed [epr_pkg::EPR_CW-1:0] i_cos [3],
    input  logic signed [epr_pkg::EPR_CW-1:0] i_sin [3],
    input  logic [2:0]                       i_flip,
    output logic signed [epr_pkg::EPR_CW-1:0] o_m [9]
);
    logic signed [epr_pkg::EPR_CW-1:0] c [3];
    logic signed [epr_pkg::EPR_CW-1:0] s [3];
    // stage A: cpcy cpsy srsp crsp crsy crcy srcp srsy srcy crcp sp cy sy
    logic signed [epr_pkg::EPR_CW-1:0] r_a [13];
    logic signed [epr_pkg::EPR_CW-1:0] r_m [9];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c[l] = i_flip[l] ? -i_cos[l] : i_cos[l];
            s[l] = i_flip[l] ? -i_sin[l] : i_sin[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_a[0]  <= epr_pkg::qmul(c[1], c[0]);
            r_a[1]  <= epr_pkg::qmul(c[1], s[0]);
            r_a[2]  <= epr_pkg::qmul(s[2], s[1]);
            r_a[3]  <= epr_pkg::qmul(c[2], s[1]);
            r_a[4]  <= epr_pkg::qmul(c[2], s[0]);
            r_a[5]  <= epr_pkg::qmul(c[2], c[0]);
            r_a[6]  <= epr_pkg::qmul(s[2], c[1]);
            r_a[7]  <= epr_pkg::qmul(s[2], s[0]);
            r_a[8]  <= epr_pkg::qmul(s[2], c[0]);
            r_a[9]  <= epr_pkg::qmul(c[2], c[1]);
            r_a[10] <= s[1];
            r_a[11] <= c[0];
            r_a[12] <= s[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_m[0] <= r_a[0];
            r_m[1] <= r_a[1];
            r_m[2] <= -r_a[10];
            r_m[3] <= epr_pkg::qmul(r_a[2], r_a[11]) - r_a[4];
            r_m[4] <= epr_pkg::qmul(r_a[2], r_a[12]) + r_a[5];
            r_m[5] <= r_a[6];
            r_m[6] <= epr_pkg::qmul(r_a[3], r_a[11]) + r_a[7];
            r_m[7] <= epr_pkg::qmul(r_a[3], r_a[12]) - r_a[8];
            r_m[8] <= r_a[9];
        end
    end

    assign o_m = r_m;
endmodule

// File: src/epr_dot.sv
`timescale 1ns / 1ps
// Matrix times point: nine products, then rounded sums and clamp.
module epr_dot #(
    parameter int COORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_en_a,
    input  logic                                i_en_b,
    input  logic signed [COORD_BITS-1:0]        i_pt [3],
    input  logic signed [epr_pkg::EPR_CW-1:0]    i_m [9],
    output logic signed [COORD_BITS-1:0]        o_r [3],
    output logic                                o_sat
);
    localparam int PW = COORD_BITS + epr_pkg::EPR_CW;
    localparam int SW = PW + 2;
    localparam int RW = SW - epr_pkg::EPR_FRAC;

    localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
    localparam logic signed [RW-1:0] MINV = RW'(-(64'sd1 <<< (COORD_BITS-1)));
    localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (epr_pkg::EPR_FRAC-1));

    logic signed [PW-1:0]         r_p [9];
    logic signed [SW-1:0]         w_sum [3];
    logic signed [RW-1:0]         w_q [3];
    logic signed [COORD_BITS-1:0] n_r [3];
    logic [2:0]                   w_clamp;
    logic signed [COORD_BITS-1:0] r_r [3];
    logic                         r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            for (int j = 0; j < 9; j++) begin
                r_p[j] <= PW'(i_pt[j % 3]) * PW'(i_m[j]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = SW'(r_p[3*k]) + SW'(r_p[3*k+1]) + SW'(r_p[3*k+2]) + HALF;
            w_q[k] = RW'(w_sum[k] >>> epr_pkg::EPR_FRAC);
            if (w_q[k] > MAXV) begin
                n_r[k] = MAXV[COORD_BITS-1:0];
                w_clamp[k] = 1'b1;
            end else if (w_q[k] < MINV) begin
                n_r[k] = MINV[COORD_BITS-1:0];
                w_clamp[k] = 1'b1;
            end else begin
                n_r[k] = w_q[k][COORD_BITS-1:0];
                w_clamp[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_r   <= n_r;
            r_sat <= |w_clamp;
        end
    end

    assign o_r   = r_r;
    assign o_sat = r_sat;
endmodule

// File: src/euler_point_rotation.sv
`timescale 1ns / 1ps
// ZYX Euler rotation of one Q16.16 point per request.
// Throughput: one request per cycle; each stage holds only while its successor is full
// and stalled, so bubbles collapse and the input fills any bubble while a result waits.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data regs are not reset.
module euler_point_rotation #(
    parameter int COORD_BITS   = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    epr_in_if.sink    i_in,
    epr_out_if.source o_out
);
    // Stage map:
    //   0                  quadrant fold of the three angles
    //   1 .. CORDIC_STEPS  one CORDIC step each (yaw, pitch, roll in parallel)
    //   N+1, N+2           rotation matrix coefficients
    //   N+3, N+4           products with the point, rounded sum and clamp (output)
    localparam int N   = CORDIC_STEPS;
    localparam int NST = N + 5;
    localparam int PAD = 32 - ANGLE_BITS;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    // Each stage loads when empty or when its successor loads.
    assign w_en[NST-1] = !r_v[NST-1] || o_out.ready;
    generate
        for (genvar k = 0; k < NST - 1; k++) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_in.valid : r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    // --- angle fold: top two bits 01/10 -> subtract half turn, negate later ---
    logic [ANGLE_BITS-1:0]              w_ang [3];
    logic [31:0]                        w_z32 [3];
    logic signed [epr_pkg::EPR_ZW-1:0]  r_z0 [3];
    logic [2:0]                         r_fl [N+1];
    logic signed [COORD_BITS-1:0]       r_pt [N+3][3];

    assign w_ang[0] = i_in.yaw_angle;
    assign w_ang[1] = i_in.pitch_angle;
    assign w_ang[2] = i_in.roll_angle;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_z32[l] = {w_ang[l], {PAD{1'b0}}};
            w_z32[l][31] = w_z32[l][31] ^ (w_z32[l][31] ^ w_z32[l][30]);
        end
    end

    // Side payload (point, fold flags) rides along with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_z0[l]    <= epr_pkg::EPR_ZW'(signed'(w_z32[l]));
                r_fl[0][l] <= w_ang[l][ANGLE_BITS-1] ^ w_ang[l][ANGLE_BITS-2];
            end
            r_pt[0][0] <= i_in.point_x;
            r_pt[0][1] <= i_in.point_y;
            r_pt[0][2] <= i_in.point_z;
        end
        for (int k = 1; k < N + 3; k++) begin
            if (w_en[k]) begin
                r_pt[k] <= r_pt[k-1];
            end
        end
        for (int k = 1; k < N + 1; k++) begin
            if (w_en[k]) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    // --- CORDIC chain ---
    logic signed [epr_pkg::EPR_CW-1:0] w_x [N+1][3];
    logic signed [epr_pkg::EPR_CW-1:0] w_y [N+1][3];
    logic signed [epr_pkg::EPR_ZW-1:0] w_z [N+1][3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_x[0][l] = epr_pkg::EPR_GAIN;
            w_y[0][l] = epr_pkg::EPR_ZERO;
            w_z[0][l] = r_z0[l];
        end
    end

    generate
        for (genvar s = 0; s < N; s++) begin : g_cordic
            epr_cordic_stage #(
                .STEP (s)
            ) u_stage (
                .i_clk (i_clk),
                .i_en  (w_en[s+1]),
                .i_x   (w_x[s]),
                .i_y   (w_y[s]),
                .i_z   (w_z[s]),
                .o_x   (w_x[s+1]),
                .o_y   (w_y[s+1]),
                .o_z   (w_z[s+1])
            );
        end
    endgenerate

    // --- coefficients ---
    logic signed [epr_pkg::EPR_CW-1:0] w_m [9];

    epr_coef u_coef (
        .i_clk  (i_clk),
        .i_en_a (w_en[N+1]),
        .i_en_b (w_en[N+2]),
        .i_cos  (w_x[N]),
        .i_sin  (w_y[N]),
        .i_flip (r_fl[N]),
        .o_m    (w_m)
    );

    // --- dot products and clamp ---
    logic signed [COORD_BITS-1:0] w_r [3];
    logic                         w_sat;

    epr_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .i_clk  (i_clk),
        .i_en_a (w_en[N+3]),
        .i_en_b (w_en[N+4]),
        .i_pt   (r_pt[N+2]),
        .i_m    (w_m),
        .o_r    (w_r),
        .o_sat  (w_sat)
    );

    assign o_out.valid          = r_v[NST-1];
    assign o_out.rotated_x      = w_r[0];
    assign o_out.rotated_y      = w_r[1];
    assign o_out.rotated_z      = w_r[2];
    assign o_out.saturated_flag = w_sat;
endmodule

// File: src/epr_checker.sv
`timescale 1ns / 1ps
module epr_checker #(
    parameter int COORD_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] i_rx,
    input logic [COORD_BITS-1:0] i_ry,
    input logic [COORD_BITS-1:0] i_rz,
    input logic                  i_sat
);
    localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rx) && $stable(i_ry)
        && $stable(i_rz) && $stable(i_sat))
        else $error("stalled result changed");

    // empty or draining output never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked while output free");

    // clamp flag implies a coordinate at a range limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_rx == MAXV || i_rx == MINV || i_ry == MAXV
        || i_ry == MINV || i_rz == MAXV || i_rz == MINV)
        else $error("saturation flag without clamped coordinate");
endmodule

bind euler_point_rotation epr_checker #(
    .COORD_BITS (COORD_BITS)
) u_epr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rx        (o_out.rotated_x),
    .i_ry        (o_out.rotated_y),
    .i_rz        (o_out.rotated_z),
    .i_sat       (o_out.saturated_flag)
);
